[rtl/dqr_pkg.sv]
// Shared types, codes and widths for the ring-buffer deque.
// No dependencies; used by dqr_ctrl and double_ended_queue_ring.
package dqr_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int OP_W      = 3;
    localparam int VAL_W     = 32;
    localparam int ST_W      = 2;
    localparam int CNT_W     = 5;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_QUERY      = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } t_state;

    typedef struct packed {
        t_status           status;
        logic [CNT_W-1:0]  count;
        logic              is_empty;
        logic              is_full;
    } t_resp;

endpackage

[rtl/dqr_ram.sv]
// Generic simple RAM: one write port, two read ports, registered read data.
// No dependencies.
module dqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read-before-write on an address clash
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

[rtl/dqr_ctrl.sv]
// Deque control: capacity register, head/tail pointers, count, status.
// Depends on dqr_pkg; drives the slot RAM addresses and the result flags.
module dqr_ctrl #(
    parameter int DEPTH = dqr_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [dqr_pkg::OP_W-1:0]   i_op,
    input  logic                       i_cfg_valid,
    input  logic [dqr_pkg::CNT_W-1:0]  i_cfg_data,
    output logic                       o_cfg_ready,
    output logic                       o_busy,
    output logic                       o_accept,
    output logic                       o_we,
    output logic [$clog2(DEPTH)-1:0]   o_waddr,
    output logic [$clog2(DEPTH)-1:0]   o_raddr_a,
    output logic [$clog2(DEPTH)-1:0]   o_raddr_b,
    output logic                       o_done,
    output dqr_pkg::t_resp             o_resp
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int IW    = (PTR_W > dqr_pkg::CNT_W ? PTR_W : dqr_pkg::CNT_W) + 1;

    dqr_pkg::t_state            r_state, n_state;
    logic [dqr_pkg::CNT_W-1:0]  r_cap_raw;
    logic [dqr_pkg::CNT_W-1:0]  cap;
    logic [PTR_W-1:0]           r_head, n_head;
    logic [PTR_W-1:0]           r_tail, n_tail;
    logic [dqr_pkg::CNT_W-1:0]  r_count, n_count;
    dqr_pkg::t_resp             r_resp, n_resp;
    logic [PTR_W-1:0]           cap_last;
    logic [PTR_W-1:0]           head_prev, head_next, tail_prev, tail_next, ntail_prev;
    logic                       full, empty, acc, cfg_wr;
    dqr_pkg::t_status           status;

    // clamp the register to 1..DEPTH
    always_comb begin
        if (r_cap_raw == '0) begin
            cap = dqr_pkg::CNT_W'(1);
        end else if (32'(r_cap_raw) > DEPTH) begin
            cap = dqr_pkg::CNT_W'(DEPTH);
        end else begin
            cap = r_cap_raw;
        end
    end

    assign cap_last  = PTR_W'(cap - dqr_pkg::CNT_W'(1));
    assign head_prev = (r_head == '0) ? cap_last : r_head - PTR_W'(1);
    assign tail_prev = (r_tail == '0) ? cap_last : r_tail - PTR_W'(1);
    assign head_next = (IW'(r_head) + IW'(1) == IW'(cap)) ? '0 : r_head + PTR_W'(1);
    assign tail_next = (IW'(r_tail) + IW'(1) == IW'(cap)) ? '0 : r_tail + PTR_W'(1);

    assign full   = (r_count >= cap);
    assign empty  = (r_count == '0);
    assign o_busy = (r_state == dqr_pkg::S_RESP);
    assign acc    = i_start && !o_busy;
    // config waits while a command is offered or in flight
    assign o_cfg_ready = !o_busy && !i_start;
    assign cfg_wr = i_cfg_valid && o_cfg_ready;
    assign o_accept = acc;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        status  = dqr_pkg::ST_OK;
        o_we    = 1'b0;
        o_waddr = r_tail;
        case (dqr_pkg::t_op'(i_op))
            dqr_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    status = dqr_pkg::ST_FULL;
                end else begin
                    n_head  = head_prev;
                    o_we    = acc;
                    o_waddr = head_prev;
                    n_count = r_count + dqr_pkg::CNT_W'(1);
                end
            end
            dqr_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    status = dqr_pkg::ST_FULL;
                end else begin
                    n_tail  = tail_next;
                    o_we    = acc;
                    o_waddr = r_tail;
                    n_count = r_count + dqr_pkg::CNT_W'(1);
                end
            end
            dqr_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    status = dqr_pkg::ST_EMPTY;
                end else begin
                    n_head  = head_next;
                    n_count = r_count - dqr_pkg::CNT_W'(1);
                end
            end
            dqr_pkg::OP_POP_BACK: begin
                if (empty) begin
                    status = dqr_pkg::ST_EMPTY;
                end else begin
                    n_tail  = tail_prev;
                    n_count = r_count - dqr_pkg::CNT_W'(1);
                end
            end
            default: begin
                // query and unused codes: no change
            end
        endcase
    end

    // ends after the operation
    assign ntail_prev = (n_tail == '0) ? cap_last : n_tail - PTR_W'(1);
    assign o_raddr_a  = n_head;
    assign o_raddr_b  = ntail_prev;

    always_comb begin
        n_resp.status   = status;
        n_resp.count    = n_count;
        n_resp.is_empty = (n_count == '0);
        n_resp.is_full  = (n_count == cap);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dqr_pkg::S_IDLE: begin
                if (acc) n_state = dqr_pkg::S_RESP;
            end
            dqr_pkg::S_RESP: begin
                n_state = dqr_pkg::S_IDLE;
            end
            default: begin
                n_state = dqr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dqr_pkg::S_IDLE;
            r_cap_raw <= dqr_pkg::CAP_RESET;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_cap_raw <= i_cfg_data;
                r_head    <= '0;
                r_tail    <= '0;
                r_count   <= '0;
            end else if (acc) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_resp <= n_resp;
        end
    end

    assign o_done = o_busy;
    assign o_resp = r_resp;

endmodule

[rtl/double_ended_queue_ring.sv]
// Top level of the ring-buffer deque: control, slot RAM, result forwarding.
// Depends on dqr_pkg, dqr_ctrl and dqr_ram.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  command  | start / busy               | i_op, i_value
//  result   | o_done (one-cycle strobe)  | o_status, o_count, o_is_empty,
//           |                            | o_is_full, o_first_value, o_last_value
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_data (capacity in use)
//
// For each command beat: in the accept cycle the pointers move,
// the pushed value is written to the slot RAM and both ends are addressed;
// the next cycle shows the result from the RAM's registered read ports, with
// busy high. The next command can be taken the cycle after the result.
// Reset clears the pointers and count and sets capacity 16 (clamped to DEPTH).
// The slot RAM is not cleared. The receiver cannot stall: o_done lasts one cycle.
module double_ended_queue_ring #(
    parameter int DEPTH = dqr_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [dqr_pkg::OP_W-1:0]          i_op,
    input  logic signed [dqr_pkg::VAL_W-1:0]  i_value,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dqr_pkg::CNT_W-1:0]         i_cfg_data,
    output logic                              o_done,
    output logic [dqr_pkg::ST_W-1:0]          o_status,
    output logic [dqr_pkg::CNT_W-1:0]         o_count,
    output logic                              o_is_empty,
    output logic                              o_is_full,
    output logic signed [dqr_pkg::VAL_W-1:0]  o_first_value,
    output logic signed [dqr_pkg::VAL_W-1:0]  o_last_value
);

    localparam int PTR_W = $clog2(DEPTH);

    logic                      acc;
    logic                      we;
    logic [PTR_W-1:0]          waddr, raddr_a, raddr_b;
    logic [dqr_pkg::VAL_W-1:0] rdata_a, rdata_b;
    dqr_pkg::t_resp            resp;
    logic                      r_fwd_a, r_fwd_b;
    logic [dqr_pkg::VAL_W-1:0] r_fwd_val;

    dqr_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_op        (i_op),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_busy      (busy),
        .o_accept    (acc),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_raddr_a   (raddr_a),
        .o_raddr_b   (raddr_b),
        .o_done      (o_done),
        .o_resp      (resp)
    );

    // slot RAM: front end read on port a, back end on port b
    dqr_ram #(
        .WIDTH (dqr_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (i_value),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // The RAM reads old data when the pushed slot is also an end being read
    // (always so for the pushed end); bypass the pushed value in that case.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_fwd_a   <= we && (raddr_a == waddr);
            r_fwd_b   <= we && (raddr_b == waddr);
            r_fwd_val <= i_value;
        end
    end

    assign o_status   = resp.status;
    assign o_count    = resp.count;
    assign o_is_empty = resp.is_empty;
    assign o_is_full  = resp.is_full;

    // an empty queue reports zero at both ends
    always_comb begin
        if (resp.is_empty) begin
            o_first_value = '0;
            o_last_value  = '0;
        end else begin
            o_first_value = r_fwd_a ? r_fwd_val : rdata_a;
            o_last_value  = r_fwd_b ? r_fwd_val : rdata_b;
        end
    end

endmodule

[tb/double_ended_queue_ring_test.sv]
// Testbench for double_ended_queue_ring: a shadow deque predicts every response.
// Depends on dqr_pkg and the double_ended_queue_ring RTL only.
module double_ended_queue_ring_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dqr_pkg::*;

    localparam int RING_DEPTH    = DEPTH_DEF;
    localparam int STALL_LIMIT   = 1000;
    localparam int REPORT_LIMIT  = 10;
    localparam int ITEMS_PER_RUN = 150;

    // Expected view of the deque after one command
    typedef struct {
        t_status            status;
        logic [CNT_W-1:0]   count;
        logic               is_empty;
        logic               is_full;
        logic [VAL_W-1:0]   first_value;
        logic [VAL_W-1:0]   last_value;
    } t_deque_view;

    // Shadow copy of the ring: takes each accepted command beat, predicts the
    // response and checks what comes back out of the block.
    class deque_shadow;
        logic [VAL_W-1:0]   slot_mem [RING_DEPTH];
        int unsigned        head_ptr;
        int unsigned        tail_ptr;
        int unsigned        held;
        logic [CNT_W-1:0]   cap_reg;
        t_deque_view        awaited [$];
        int                 mismatches;

        function new();
            foreach (slot_mem[i]) slot_mem[i] = '0;
            head_ptr   = 0;
            tail_ptr   = 0;
            held       = 0;
            cap_reg    = CAP_RESET;
            mismatches = 0;
        endfunction

        // Any write empties the deque as well
        function void write_capacity(logic [CNT_W-1:0] data);
            cap_reg  = data;
            head_ptr = 0;
            tail_ptr = 0;
            held     = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void log_command(logic [OP_W-1:0] op, logic [VAL_W-1:0] data);
            int unsigned cap;
            bit          was_full;
            bit          was_empty;
            t_deque_view v;
            cap = cap_reg;
            if (cap < 1) cap = 1;
            if (cap > RING_DEPTH) cap = RING_DEPTH;
            was_full  = (held >= cap);
            was_empty = (held == 0);
            head_ptr  = head_ptr % cap;
            tail_ptr  = tail_ptr % cap;
            v.status  = ST_OK;
            case (op)
                OP_PUSH_FRONT: begin
                    if (was_full) begin
                        v.status = ST_FULL;
                    end else begin
                        head_ptr = (head_ptr + cap - 1) % cap;
                        slot_mem[head_ptr] = data;
                        held++;
                    end
                end
                OP_PUSH_BACK: begin
                    if (was_full) begin
                        v.status = ST_FULL;
                    end else begin
                        slot_mem[tail_ptr] = data;
                        tail_ptr = (tail_ptr + 1) % cap;
                        held++;
                    end
                end
                OP_POP_FRONT: begin
                    if (was_empty) begin
                        v.status = ST_EMPTY;
                    end else begin
                        head_ptr = (head_ptr + 1) % cap;
                        held--;
                    end
                end
                OP_POP_BACK: begin
                    if (was_empty) begin
                        v.status = ST_EMPTY;
                    end else begin
                        tail_ptr = (tail_ptr + cap - 1) % cap;
                        held--;
                    end
                end
                default: ;  // query, and unused codes act as query
            endcase
            v.count       = CNT_W'(held);
            v.is_empty    = (held == 0);
            v.is_full     = (held == cap);
            v.first_value = '0;
            v.last_value  = '0;
            if (held != 0) begin
                v.first_value = slot_mem[head_ptr % cap];
                v.last_value  = slot_mem[(tail_ptr + cap - 1) % cap];
            end
            awaited.push_back(v);
        endfunction

        function void compare_field(string name, logic [VAL_W-1:0] want,
                                    logic [VAL_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: %s mismatch, expected %0h got %0h",
                             $realtime, name, want, got);
            end
        endfunction

        function void check_response(logic [ST_W-1:0] status, logic [CNT_W-1:0] count,
                                     logic is_empty, logic is_full,
                                     logic [VAL_W-1:0] first_value,
                                     logic [VAL_W-1:0] last_value);
            t_deque_view v;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: response with none expected", $realtime);
                return;
            end
            v = awaited.pop_front();
            compare_field("status", VAL_W'(v.status), VAL_W'(status));
            compare_field("count", VAL_W'(v.count), VAL_W'(count));
            compare_field("is_empty", VAL_W'(v.is_empty), VAL_W'(is_empty));
            compare_field("is_full", VAL_W'(v.is_full), VAL_W'(is_full));
            compare_field("first_value", v.first_value, first_value);
            compare_field("last_value", v.last_value, last_value);
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [OP_W-1:0]            i_op;
    logic signed [VAL_W-1:0]    i_value;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CNT_W-1:0]           i_cfg_data;
    logic                       o_done;
    logic [ST_W-1:0]            o_status;
    logic [CNT_W-1:0]           o_count;
    logic                       o_is_empty;
    logic                       o_is_full;
    logic signed [VAL_W-1:0]    o_first_value;
    logic signed [VAL_W-1:0]    o_last_value;

    deque_shadow shadow = new();
    int          sender_idle_pct = 0;
    int          quiet_cycles    = 0;
    bit          push_trend      = 1'b1;

    double_ended_queue_ring dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_value       (i_value),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_count       (o_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .o_first_value (o_first_value),
        .o_last_value  (o_last_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Monitor: everything is sampled at the rising edge, before the block's
    // registers move. Config beat, command beat and response all land here.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1)
                shadow.write_capacity(i_cfg_data);
            if (o_done === 1'b1)
                shadow.check_response(o_status, o_count, o_is_empty, o_is_full,
                                      o_first_value, o_last_value);
            if (start === 1'b1 && busy === 1'b0)
                shadow.log_command(i_op, i_value);
        end
    end

    // Watchdog: any beat or response resets the count of dead cycles
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1 ||
            (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // All driving happens at the falling edge, with blocking assignments.
    // Start stays high across back-to-back beats; it only drops for idle gaps.
    task automatic send_command(logic [OP_W-1:0] op, logic [VAL_W-1:0] data);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start   = 1'b1;
        i_op    = op;
        i_value = data;
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    // Hold off until every outstanding response is back
    task automatic drain_responses();
        start = 1'b0;
        while (shadow.pending() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // Capacity writes only once the block has gone quiet
    task automatic write_capacity(logic [CNT_W-1:0] cap);
        drain_responses();
        i_cfg_valid = 1'b1;
        i_cfg_data  = cap;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Extremes show up often; the rest is uniform
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Pushes or pops dominate in stretches so the ring fills, wraps and empties
    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return OP_W'($urandom_range(5, 7));
        if (r < 8) return OP_QUERY;
        if ((r < 73) == push_trend)
            return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    initial begin
        logic [CNT_W-1:0] cap_plan [9];
        int               idle_plan [3];
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_op        = OP_QUERY;
        i_value     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        cap_plan    = '{5'd16, 5'd0, 5'd31, 5'd17, 5'd1, 5'd2, 5'd3, 5'd8, 5'd16};
        cap_plan[7] = CNT_W'($urandom_range(3, 15));
        idle_plan   = '{0, 75, 16};

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: empty-queue errors, unused op codes, value extremes at
        // both ends, then draining back to empty at the default capacity
        send_command(OP_QUERY, 32'h1234_5678);
        send_command(OP_POP_FRONT, '0);
        send_command(OP_POP_BACK, '1);
        send_command(3'd5, '0);
        send_command(3'd6, '0);
        send_command(3'd7, '1);
        send_command(OP_PUSH_BACK, 32'h7FFF_FFFF);
        send_command(OP_PUSH_FRONT, 32'h8000_0000);
        send_command(OP_PUSH_BACK, '0);
        send_command(OP_PUSH_FRONT, '1);
        send_command(OP_QUERY, '0);
        send_command(OP_POP_FRONT, '0);
        send_command(OP_POP_BACK, '0);
        send_command(OP_POP_BACK, '0);
        send_command(OP_POP_BACK, '0);
        send_command(OP_POP_FRONT, '0);

        // Single-entry ring: full refusal on either end, then empty refusal
        write_capacity(5'd1);
        send_command(OP_PUSH_FRONT, 32'hA5A5_5A5A);
        send_command(OP_PUSH_BACK, 32'h0000_0001);
        send_command(OP_PUSH_FRONT, 32'h0000_0002);
        send_command(OP_POP_BACK, '0);
        send_command(OP_PUSH_BACK, 32'h5A5A_A5A5);
        send_command(OP_POP_FRONT, '0);
        send_command(OP_POP_FRONT, '0);

        // Random phases: each starts with a capacity write (zero and values
        // beyond the ring are clamped) and cycles through the idle rates
        foreach (cap_plan[p]) begin
            write_capacity(cap_plan[p]);
            sender_idle_pct = idle_plan[p % 3];
            for (int n = 0; n < ITEMS_PER_RUN; n++) begin
                if (n % 20 == 0) push_trend = 1'($urandom_range(0, 1));
                // mid-phase hold-off until the block has answered everything
                if (n == ITEMS_PER_RUN / 2) drain_responses();
                send_command(pick_op(), pick_value());
            end
        end

        drain_responses();
        repeat (4) @(negedge i_clk);
        if (shadow.mismatches == 0 && shadow.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
